>>> hw/rtl/swb_pkg.sv
// swb_pkg: item kinds, status codes and fixed field widths of the sequence window buffer
// no dependencies; imported by sequence_window_buffer
`timescale 1ns / 1ps

package swb_pkg;

  // fixed field widths of the stream items
  localparam int unsigned StepW  = 32;
  localparam int unsigned StampW = 32;
  localparam int unsigned SlotOutW  = 6;
  localparam int unsigned CountOutW = 7;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned KindW     = 2;

  // stream payload widths
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 112;

  // configuration port
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam logic [ApbAddrW-1:0] AddrStartStep = 3'd0;

  typedef enum logic [KindW-1:0] {
    KIND_ADD     = 2'd0,
    KIND_DISCARD = 2'd1,
    KIND_LOOKUP  = 2'd2
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_FUTURE = 3'd3,
    ST_OLD    = 3'd4
  } status_e;

endpackage

>>> hw/rtl/swb_ram.sv
// swb_ram: generic single-write, single-read memory with registered read data
// no dependencies; used for the timestamp store of sequence_window_buffer
`timescale 1ns / 1ps

module swb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/sequence_window_buffer.sv
// sequence_window_buffer: ring window of timestamped step entries keyed by step number
// depends on swb_pkg and swb_ram
`timescale 1ns / 1ps
// result: valid in the cycle after its item is accepted (stamp memory read port)
// throughput: one item per cycle; an item is taken whenever the output register is
//   empty or is being emptied in the same cycle
// reset: pointers and count clear, start step and both step counters go to 0;
//   the stamp memory is not cleared and holds nothing readable until written by an add

module sequence_window_buffer
  import swb_pkg::*;
#(
  parameter int unsigned WINDOW = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // item input
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InDataW-1:0]   s_axis_tdata,   // query_step[31:0], stamp[63:32]
  input  logic [KindW-1:0]     s_axis_tuser,   // kind[1:0]
  // result output
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // slot_index[5:0], found_stamp[37:6], assigned_step[69:38], in_window[70],
  // newest_step[102:71], entry_count[109:103], zero pad[111:110]
  output logic [OutDataW-1:0]  m_axis_tdata,
  output logic [StatusW-1:0]   m_axis_tuser,   // status[2:0]
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ApbAddrW-1:0]  paddr,
  input  logic [ApbDataW-1:0]  pwdata,
  output logic [ApbDataW-1:0]  prdata,
  output logic                 pready
);

  localparam int unsigned SlotW = $clog2(WINDOW);
  localparam int unsigned CntW  = $clog2(WINDOW + 1);
  localparam logic [SlotW:0]   WinExt  = (SlotW + 1)'(WINDOW);
  localparam logic [SlotW:0]   WinLast = (SlotW + 1)'(WINDOW - 1);
  localparam logic [CntW-1:0]  WinCnt  = CntW'(WINDOW);

  // configuration register
  logic [StepW-1:0] start_step_q;
  logic             cfg_we;

  // window state
  logic [SlotW-1:0] head_q, head_d;
  logic [SlotW-1:0] tail_q, tail_d;
  logic [CntW-1:0]  held_q, held_d;
  logic [StepW-1:0] oldest_q, oldest_d;
  logic [StepW-1:0] next_step_q, next_step_d;

  // output register
  logic                 out_valid_q;
  status_e              status_q, status_d;
  logic [SlotOutW-1:0]  slot_q, slot_d;
  logic                 hit_q, hit_d;
  logic [StepW-1:0]     assigned_q, assigned_d;
  logic                 inwin_q, inwin_d;
  logic [StepW-1:0]     newest_q, newest_d;
  logic [CountOutW-1:0] count_q, count_d;

  // item fields and working values
  logic              accept;
  logic [StepW-1:0]  query_step;
  logic [StampW-1:0] stamp;
  logic [StepW-1:0]  back;
  logic [StepW-1:0]  drop_raw;
  logic [CntW-1:0]   drop;
  logic [SlotW:0]    tail_sum;
  logic [SlotW:0]    look_sum;
  logic [SlotW-1:0]  look_slot;
  logic [SlotW+SlotOutW-1:0] slot_wide;
  logic [CntW+CountOutW-1:0] count_wide;
  logic              mem_we;
  logic              mem_re;
  logic [StampW-1:0] mem_rdata;
  logic [StampW-1:0] found_stamp;

  assign query_step = s_axis_tdata[StepW-1:0];
  assign stamp      = s_axis_tdata[InDataW-1:StepW];

  // output register parts the two sides; a new item enters as the old result leaves
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // apb: always ready, one register
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == AddrStartStep);
  assign prdata = (paddr == AddrStartStep) ? start_step_q : '0;

  always_comb begin
    // distance back from the newest step, and ring arithmetic for discard and lookup
    back      = (next_step_q - StepW'(1)) - query_step;
    drop_raw  = query_step - oldest_q;
    drop      = (drop_raw > StepW'(held_q)) ? held_q : drop_raw[CntW-1:0];
    tail_sum  = {1'b0, tail_q} + (SlotW + 1)'(drop);
    // back is below held count here, so the wrapped sum needs one correction at most
    look_sum  = {1'b0, head_q} + WinLast - {1'b0, back[SlotW-1:0]};
    look_slot = (look_sum >= WinExt) ? SlotW'(look_sum - WinExt) : look_sum[SlotW-1:0];

    head_d      = head_q;
    tail_d      = tail_q;
    held_d      = held_q;
    oldest_d    = oldest_q;
    next_step_d = next_step_q;
    status_d    = ST_OK;
    hit_d       = 1'b0;
    assigned_d  = '0;
    slot_wide   = '0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;

    if (accept) begin
      case (s_axis_tuser)
        KIND_ADD: begin
          if (held_q >= WinCnt) begin
            status_d = ST_FULL;
          end else begin
            mem_we      = 1'b1;
            assigned_d  = next_step_q;
            head_d      = ({1'b0, head_q} == WinLast) ? '0 : head_q + SlotW'(1);
            held_d      = held_q + CntW'(1);
            next_step_d = next_step_q + StepW'(1);
          end
        end
        KIND_DISCARD: begin
          // ignored on an empty window or an old step
          if (held_q != '0 && query_step >= oldest_q) begin
            if (query_step >= next_step_q) begin
              held_d   = '0;
              oldest_d = next_step_q;
              tail_d   = head_q;
            end else begin
              tail_d   = (tail_sum >= WinExt) ? SlotW'(tail_sum - WinExt)
                                              : tail_sum[SlotW-1:0];
              oldest_d = query_step;
              held_d   = held_q - drop;
            end
          end
        end
        KIND_LOOKUP: begin
          if (held_q == '0) begin
            status_d = ST_EMPTY;
          end else if (back[StepW-1]) begin
            status_d = ST_FUTURE;
          end else if (back >= StepW'(held_q)) begin
            status_d = ST_OLD;
          end else begin
            mem_re    = 1'b1;
            hit_d     = 1'b1;
            slot_wide = (SlotW + SlotOutW)'(look_slot);
          end
        end
        default: begin
          // unused kind code: no state change, status ok
        end
      endcase
    end

    slot_d     = slot_wide[SlotOutW-1:0];
    inwin_d    = (query_step >= oldest_d) && (query_step < next_step_d);
    newest_d   = (held_d == '0) ? '1 : next_step_d - StepW'(1);
    count_wide = (CntW + CountOutW)'(held_d);
    count_d    = count_wide[CountOutW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_step_q <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      held_q       <= '0;
      oldest_q     <= '0;
      next_step_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      // a start step write re-opens an empty window at that step
      if (cfg_we) begin
        start_step_q <= pwdata;
        head_q       <= '0;
        tail_q       <= '0;
        held_q       <= '0;
        oldest_q     <= pwdata;
        next_step_q  <= pwdata;
      end else begin
        head_q      <= head_d;
        tail_q      <= tail_d;
        held_q      <= held_d;
        oldest_q    <= oldest_d;
        next_step_q <= next_step_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded when an item is taken
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q   <= status_d;
      slot_q     <= slot_d;
      hit_q      <= hit_d;
      assigned_q <= assigned_d;
      inwin_q    <= inwin_d;
      newest_q   <= newest_d;
      count_q    <= count_d;
    end
  end

  // stamp store; read data holds until the next lookup hit is taken
  swb_ram #(
    .Width(StampW),
    .Depth(WINDOW)
  ) u_stamp_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(head_q),
    .wdata_i(stamp),
    .re_i   (mem_re),
    .raddr_i(look_slot),
    .rdata_o(mem_rdata)
  );

  assign found_stamp   = hit_q ? mem_rdata : '0;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {2'b00, count_q, newest_q, inwin_q, assigned_q, found_stamp, slot_q};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= WinCnt)
    else $error("held count exceeds window size");

  a_step_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_step_q - oldest_q) == StepW'(held_q))
    else $error("step span disagrees with held count");

  a_ring_pointers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (({1'b0, tail_q} + (SlotW + 1)'(held_q)) == {1'b0, head_q}) ||
    (({1'b0, tail_q} + (SlotW + 1)'(held_q)) == ({1'b0, head_q} + WinExt)))
    else $error("head and tail pointers disagree with held count");
`endif

endmodule
